>>> hw/rtl/tga_rle_scanline_decoder_assert.svh
// Assertion macros for the scan-line decoder. Both expect clk and arst_n in scope.
`ifndef TGA_RLE_SCANLINE_DECODER_ASSERT_SVH
`define TGA_RLE_SCANLINE_DECODER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define TRD_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("decoder assertion failed");
`define TRD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("decoder assertion failed");
`else
`define TRD_ASSERT(lbl, prop)
`define TRD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> hw/rtl/trd_pkg.sv
package trd_pkg;

	localparam logic REG_PIXEL_SIZE  = 1'b0;
	localparam logic REG_LINE_LENGTH = 1'b1;

	localparam logic [2:0]  PIXEL_SIZE_RESET  = 3'd3;
	localparam logic [15:0] LINE_LENGTH_RESET = 16'd640;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	typedef struct packed {
		logic [2:0]  pixel_size;
		logic [15:0] line_length;
	} cfg_t;

	// one decoded packet event for the output side
	typedef struct packed {
		logic        err;
		logic        eol;
		logic [7:0]  count;
		logic [31:0] pix;
	} cmd_t;

endpackage

>>> hw/rtl/trd_front.sv
module trd_front #(
	parameter int PIX_BYTES = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  trd_pkg::cfg_t cfg,
	input  logic          data_valid,
	input  logic [7:0]    data_byte,
	output logic          data_stall,
	input  logic          q_full,
	output logic          q_push,
	output trd_pkg::cmd_t q_cmd
);

	localparam int GW = 8 * PIX_BYTES;
	localparam logic [2:0] MAXB = 3'(PIX_BYTES);

	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_REPEAT = 2'd1;
	localparam logic [1:0] PH_RAW    = 2'd2;

	logic [1:0]    phase_q;
	logic [7:0]    packet_left_q;
	logic [1:0]    byte_idx_q;
	logic [GW-1:0] gather_q;
	logic [15:0]   line_done_q;

	logic          accept;
	logic          in_pixel;
	logic [2:0]    psize;
	logic          byte_last;
	logic [GW-1:0] gather_new;
	logic [7:0]    hdr_count;
	logic          overrun;
	logic [15:0]   line_add;
	logic [15:0]   line_sum;
	logic          line_hit;
	logic [7:0]    left_dec;

	assign data_stall = q_full;
	assign accept     = data_valid && !q_full;
	assign in_pixel   = (phase_q == PH_REPEAT) || (phase_q == PH_RAW);

	always_comb begin
		if (cfg.pixel_size == 3'd0)
			psize = 3'd1;
		else if (cfg.pixel_size > MAXB)
			psize = MAXB;
		else
			psize = cfg.pixel_size;
	end

	assign byte_last  = ({1'b0, byte_idx_q} + 3'd1) >= psize;
	assign gather_new = gather_q | (GW'(data_byte) << {byte_idx_q, 3'b000});

	assign hdr_count = {1'b0, data_byte[6:0]} + 8'd1;
	assign overrun   = ({1'b0, line_done_q} + 17'(hdr_count)) > {1'b0, cfg.line_length};

	// a repeat run lands all its pixels at once, a raw pixel just one
	assign line_add = (phase_q == PH_REPEAT) ? 16'(packet_left_q) : 16'd1;
	assign line_sum = line_done_q + line_add;
	assign line_hit = line_sum == cfg.line_length;
	assign left_dec = (packet_left_q != 8'd0) ? packet_left_q - 8'd1 : 8'd0;

	always_comb begin
		q_push      = 1'b0;
		q_cmd.err   = 1'b0;
		q_cmd.eol   = line_hit;
		q_cmd.count = (phase_q == PH_REPEAT) ? packet_left_q : 8'd1;
		q_cmd.pix   = 32'(gather_new);
		if (accept) begin
			if (!in_pixel) begin
				if (overrun) begin
					q_push      = 1'b1;
					q_cmd.err   = 1'b1;
					q_cmd.eol   = 1'b0;
					q_cmd.count = 8'd0;
					q_cmd.pix   = 32'd0;
				end
			end else if (byte_last) begin
				q_push = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HEADER;
			packet_left_q <= 8'd0;
			byte_idx_q    <= 2'd0;
			gather_q      <= '0;
			line_done_q   <= 16'd0;
		end else if (accept) begin
			if (!in_pixel) begin
				if (overrun) begin
					line_done_q <= 16'd0;
					phase_q     <= PH_HEADER;
				end else begin
					packet_left_q <= hdr_count;
					byte_idx_q    <= 2'd0;
					gather_q      <= '0;
					phase_q       <= data_byte[7] ? PH_REPEAT : PH_RAW;
				end
			end else if (!byte_last) begin
				gather_q   <= gather_new;
				byte_idx_q <= byte_idx_q + 2'd1;
			end else begin
				gather_q    <= '0;
				byte_idx_q  <= 2'd0;
				line_done_q <= line_hit ? 16'd0 : line_sum;
				if (phase_q == PH_REPEAT) begin
					packet_left_q <= 8'd0;
					phase_q       <= PH_HEADER;
				end else begin
					packet_left_q <= left_dec;
					if (left_dec == 8'd0)
						phase_q <= PH_HEADER;
				end
			end
		end
	end

endmodule

>>> hw/rtl/trd_queue.sv
module trd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  trd_pkg::cmd_t push_cmd,
	input  logic          pop,
	output logic          full,
	output logic          empty,
	output trd_pkg::cmd_t head
);

	trd_pkg::cmd_t                 entries_q [trd_pkg::QUEUE_DEPTH];
	logic [trd_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [trd_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [trd_pkg::QPTR_W:0]     fill_q;

	assign full  = fill_q == (trd_pkg::QPTR_W + 1)'(trd_pkg::QUEUE_DEPTH);
	assign empty = fill_q == '0;
	assign head  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entries_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				fill_q <= fill_q + 1'b1;
			else if (pop && !push)
				fill_q <= fill_q - 1'b1;
		end
	end

endmodule

>>> hw/rtl/trd_back.sv
module trd_back #(
	parameter int LANES = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  trd_pkg::cmd_t head,
	output logic          q_pop,
	output logic          result_valid,
	input  logic          result_stall,
	output logic [31:0]   pixel_a,
	output logic [31:0]   pixel_b,
	output logic [31:0]   pixel_c,
	output logic [31:0]   pixel_d,
	output logic [2:0]    pixel_count,
	output logic          end_of_line,
	output logic          overflow_error,
	output logic          last_result
);

	localparam logic [7:0] LANES_W = 8'(LANES);

	logic        active_q;
	logic [7:0]  left_q;
	logic        out_valid_q;
	logic [31:0] pix_q [4];
	logic [2:0]  count_q;
	logic        eol_q;
	logic        err_q;
	logic        last_q;

	logic        load;
	logic [7:0]  cur_left;
	logic [7:0]  take;
	logic [7:0]  rem;
	logic        final_res;

	assign load     = !q_empty && (!out_valid_q || !result_stall);
	assign cur_left = active_q ? left_q : head.count;

	always_comb begin
		if (head.err)
			take = 8'd0;
		else if (cur_left < LANES_W)
			take = cur_left;
		else
			take = LANES_W;
	end

	assign rem       = cur_left - take;
	assign final_res = head.err || (rem == 8'd0);
	assign q_pop     = load && final_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			left_q      <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				active_q    <= !final_res;
				left_q      <= rem;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < 4; i++)
				pix_q[i] <= (8'(i) < take) ? head.pix : 32'd0;
			count_q <= take[2:0];
			eol_q   <= final_res && head.eol;
			err_q   <= head.err;
			last_q  <= final_res;
		end
	end

	assign result_valid   = out_valid_q;
	assign pixel_a        = pix_q[0];
	assign pixel_b        = pix_q[1];
	assign pixel_c        = pix_q[2];
	assign pixel_d        = pix_q[3];
	assign pixel_count    = count_q;
	assign end_of_line    = eol_q;
	assign overflow_error = err_q;
	assign last_result    = last_q;

endmodule

>>> hw/rtl/tga_rle_scanline_decoder.sv
// Targa run-length scan-line decoder. Takes one compressed byte per cycle, and a raw pixel
// leaves as a result with one pixel. A repeat run is handed to the output side as a single
// request and leaves as ceil(count / lanes) results, one per cycle while result_stall is low,
// so a 128-pixel run with four lanes gives 32 results; the byte input stalls only once the
// four-entry request queue between the byte side and the output side is full. An overrunning
// header gives one error result and starts a new line. Pixel size and line length are to be
// written through the register port only while the decoder is idle; the user is bound to
// this, and the decoder itself does not enforce it.
`include "tga_rle_scanline_decoder_assert.svh"

module tga_rle_scanline_decoder #(
	parameter int OUT_LANES       = 4,
	parameter int MAX_PIXEL_BYTES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        write_enable,
	input  logic        reg_index,
	input  logic [15:0] write_data,
	input  logic        data_valid,
	output logic        data_stall,
	input  logic [7:0]  data_byte,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [31:0] pixel_a,
	output logic [31:0] pixel_b,
	output logic [31:0] pixel_c,
	output logic [31:0] pixel_d,
	output logic [2:0]  pixel_count,
	output logic        end_of_line,
	output logic        overflow_error,
	output logic        last_result
);

	localparam int LANES = (OUT_LANES > 4) ? 4 : ((OUT_LANES < 1) ? 1 : OUT_LANES);

	trd_pkg::cfg_t cfg_q;
	trd_pkg::cmd_t push_cmd;
	trd_pkg::cmd_t head;
	logic          q_push;
	logic          q_pop;
	logic          q_full;
	logic          q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixel_size  <= trd_pkg::PIXEL_SIZE_RESET;
			cfg_q.line_length <= trd_pkg::LINE_LENGTH_RESET;
		end else if (write_enable) begin
			case (reg_index)
				trd_pkg::REG_PIXEL_SIZE:  cfg_q.pixel_size  <= write_data[2:0];
				trd_pkg::REG_LINE_LENGTH: cfg_q.line_length <= write_data;
				default: ;
			endcase
		end
	end

	trd_front #(
		.PIX_BYTES(MAX_PIXEL_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.data_valid (data_valid),
		.data_byte  (data_byte),
		.data_stall (data_stall),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_cmd      (push_cmd)
	);

	trd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.pop      (q_pop),
		.full     (q_full),
		.empty    (q_empty),
		.head     (head)
	);

	trd_back #(
		.LANES(LANES)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (q_empty),
		.head           (head),
		.q_pop          (q_pop),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.pixel_a        (pixel_a),
		.pixel_b        (pixel_b),
		.pixel_c        (pixel_c),
		.pixel_d        (pixel_d),
		.pixel_count    (pixel_count),
		.end_of_line    (end_of_line),
		.overflow_error (overflow_error),
		.last_result    (last_result)
	);

	`TRD_ASSERT(a_no_push_when_full, !(q_push && q_full))
	`TRD_ASSERT(a_pop_needs_entry, !(q_pop && q_empty))
	`TRD_ASSERT(a_error_shape, !(result_valid && overflow_error) || (pixel_count == 3'd0 && last_result && !end_of_line))
	`TRD_ASSERT(a_lane_limit, !result_valid || (32'(pixel_count) <= LANES))
	`TRD_ASSERT_NEXT(a_run_continues, result_valid && !result_stall && !last_result, result_valid)

endmodule
